FILE: design/irps_pkg.sv
// ----------------------------------------------------------------------------
// irps_pkg
// Shared types, register codes and constants of the ir proximity scan block.
// ----------------------------------------------------------------------------
package irps_pkg;

    // default parameter values
    localparam int CHANNELS_DEF = 10;
    localparam int SAMPLES_DEF  = 3;

    // field widths
    localparam int CH_W       = 4;
    localparam int LVL_W      = 12;
    localparam int SUM_W      = 14;
    localparam int TICK_W     = 8;
    localparam int MAP_BITS   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;

    // conversion constants
    localparam int ADC_BITS      = 12;
    localparam int FULL_SCALE_MV = 3300;
    localparam int LVL_SHIFT     = 30;
    localparam int MULT_W        = 30;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_RING   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_CENTER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LEFT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_RIGHT  = 3'd5;

    // reset values of the registers
    localparam logic [TICK_W-1:0] INTERVAL_RST = 8'd2;
    localparam logic [LVL_W-1:0]  THR_RING_RST = 12'd60;
    localparam logic [LVL_W-1:0]  THR_CTR_RST  = 12'd60;
    localparam logic [LVL_W-1:0]  THR_EDGE_RST = 12'd100;

    // channels with a threshold of their own
    localparam int CH_CENTER = 7;
    localparam int CH_LEFT   = 8;
    localparam int CH_RIGHT  = 9;

    typedef struct packed {
        logic              scan_enable;
        logic [TICK_W-1:0] interval_ticks;
        logic [LVL_W-1:0]  threshold_ring;
        logic [LVL_W-1:0]  threshold_center;
        logic [LVL_W-1:0]  threshold_left;
        logic [LVL_W-1:0]  threshold_right;
    } t_cfg;

    typedef struct packed {
        logic [MAP_BITS-1:0] obstacle_map;
        logic                level_valid;
        logic [LVL_W-1:0]    level_mv;
        logic                measure_request;
        logic [CH_W-1:0]     channel;
    } t_result;

    function automatic logic [LVL_W-1:0] thr_for(input int ch, input t_cfg cfg);
        logic [LVL_W-1:0] thr;
        case (ch)
            CH_CENTER: thr = cfg.threshold_center;
            CH_LEFT:   thr = cfg.threshold_left;
            CH_RIGHT:  thr = cfg.threshold_right;
            default:   thr = cfg.threshold_ring;
        endcase
        return thr;
    endfunction

endpackage

FILE: design/irps_level.sv
// ----------------------------------------------------------------------------
// irps_level
// Converts the emitter on/off sample sums into a level in millivolts.
// ----------------------------------------------------------------------------
module irps_level #(
    parameter int SAMPLES = irps_pkg::SAMPLES_DEF
) (
    input  logic [irps_pkg::SUM_W-1:0] i_on_sum,
    input  logic [irps_pkg::SUM_W-1:0] i_off_sum,
    output logic [irps_pkg::LVL_W-1:0] o_level_mv
);

    localparam int PROD_W = irps_pkg::SUM_W + irps_pkg::MULT_W;

    // ceil(3300 * 2^30 / (4096 * SAMPLES)); exact floor for all 14-bit diffs
    localparam longint MULT = (longint'(irps_pkg::FULL_SCALE_MV)
        * (longint'(1) << (irps_pkg::LVL_SHIFT - irps_pkg::ADC_BITS))
        + longint'(SAMPLES) - 1) / longint'(SAMPLES);

    localparam logic [irps_pkg::MULT_W-1:0] MULT_V = irps_pkg::MULT_W'(MULT);
    localparam logic [irps_pkg::SUM_W-1:0]  FULL_V =
        irps_pkg::SUM_W'(irps_pkg::FULL_SCALE_MV);

    logic [irps_pkg::SUM_W-1:0] diff;
    logic [PROD_W-1:0]          prod;
    logic [irps_pkg::SUM_W-1:0] quot;

    always_comb begin
        diff = (i_off_sum > i_on_sum) ? (i_off_sum - i_on_sum) : '0;
        prod = PROD_W'(diff) * PROD_W'(MULT_V);
        quot = prod[PROD_W-1:irps_pkg::LVL_SHIFT];
        // sums beyond full scale clip
        if (quot > FULL_V) begin
            o_level_mv = irps_pkg::LVL_W'(irps_pkg::FULL_SCALE_MV);
        end else begin
            o_level_mv = quot[irps_pkg::LVL_W-1:0];
        end
    end

endmodule

FILE: design/irps_seq.sv
// ----------------------------------------------------------------------------
// irps_seq
// Scan sequencer: channel, phase and tick count, level store, obstacle map.
// ----------------------------------------------------------------------------
module irps_seq #(
    parameter int CHANNELS = irps_pkg::CHANNELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  irps_pkg::t_cfg             i_cfg,
    input  logic                       i_restart,
    input  logic                       i_fire,
    input  logic                       i_kind,
    input  logic [irps_pkg::LVL_W-1:0] i_level_mv,
    output irps_pkg::t_result          o_result
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST_CH = IDX_W'(CHANNELS - 1);

    logic [IDX_W-1:0]            r_ch,    n_ch;
    logic                        r_wait,  n_wait;
    logic [irps_pkg::TICK_W-1:0] r_ticks, n_ticks;
    logic [irps_pkg::LVL_W-1:0]  r_levels [CHANNELS];
    logic [irps_pkg::LVL_W-1:0]  n_levels [CHANNELS];

    logic                        wr_level;
    logic                        level_valid;
    logic [irps_pkg::LVL_W-1:0]  level_out;
    logic [irps_pkg::TICK_W-1:0] ticks_inc;
    logic [irps_pkg::MAP_BITS-1:0] map;

    always_comb begin
        n_ch        = r_ch;
        n_wait      = r_wait;
        n_ticks     = r_ticks;
        wr_level    = 1'b0;
        level_valid = 1'b0;
        level_out   = '0;
        ticks_inc   = (r_ticks != irps_pkg::TICK_MAX) ? (r_ticks + 1'b1) : r_ticks;
        if (!i_cfg.scan_enable) begin
            n_ch    = '0;
            n_wait  = 1'b0;
            n_ticks = '0;
        end else if (i_kind) begin
            // measurement while waiting is dropped
            if (!r_wait) begin
                wr_level    = 1'b1;
                level_valid = 1'b1;
                level_out   = i_level_mv;
                n_wait      = 1'b1;
                n_ticks     = '0;
            end
        end else if (r_wait) begin
            if (ticks_inc >= i_cfg.interval_ticks) begin
                n_ch    = (r_ch == LAST_CH) ? '0 : (r_ch + 1'b1);
                n_wait  = 1'b0;
                n_ticks = '0;
            end else begin
                n_ticks = ticks_inc;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            n_levels[i] = (wr_level && (r_ch == IDX_W'(i))) ? i_level_mv : r_levels[i];
        end
    end

    // channels past the map width are stored but not reported
    for (genvar g = 0; g < irps_pkg::MAP_BITS; g++) begin : g_map
        if (g < CHANNELS) begin : g_bit
            assign map[g] = (n_levels[g] >= irps_pkg::thr_for(g, i_cfg));
        end else begin : g_none
            assign map[g] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch    <= '0;
            r_wait  <= 1'b0;
            r_ticks <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_levels[i] <= '0;
            end
        end else if (i_restart) begin
            r_ch    <= '0;
            r_wait  <= 1'b0;
            r_ticks <= '0;
        end else if (i_fire) begin
            r_ch    <= n_ch;
            r_wait  <= n_wait;
            r_ticks <= n_ticks;
            if (wr_level) begin
                r_levels[r_ch] <= i_level_mv;
            end
        end
    end

    always_comb begin
        o_result.channel         = irps_pkg::CH_W'(n_ch);
        o_result.measure_request = i_cfg.scan_enable && !n_wait;
        o_result.level_mv        = level_out;
        o_result.level_valid     = level_valid;
        o_result.obstacle_map    = map;
    end

endmodule

FILE: design/ir_proximity_scan_sequencer.sv
// ----------------------------------------------------------------------------
// ir_proximity_scan_sequencer
// Ambient-cancelled ir proximity scan over a ring of emitter/receiver pairs.
// ----------------------------------------------------------------------------
// Input stream (i_s_*): one transaction is either a tick (tuser 0) or a
// measurement (tuser 1) carrying the on/off adc sample sums of the channel
// the block last asked for. Every input transaction gives exactly one output
// transaction (o_m_*): current channel, measure request, the level stored by
// a measurement and the obstacle map of all stored levels against their
// group thresholds.
// Configuration goes through the plain write port (i_cfg_*), one register a
// cycle, while the stream is idle; writing scan_enable restarts the scan at
// channel zero and keeps the stored levels.
// An accepted item is held in the input register and its result is then
// registered in the result register. Throughput is one item per cycle
// while the receiver takes results, set by the single input register and
// single result register. Reset clears the channel, phase, tick count, all
// stored levels and the registers to their defaults. When the receiver
// stalls, the result holds and one more item is taken into the input
// register before o_s_tready drops.
// ----------------------------------------------------------------------------
module ir_proximity_scan_sequencer #(
    parameter int CHANNELS = irps_pkg::CHANNELS_DEF,
    parameter int SAMPLES  = irps_pkg::SAMPLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // on_sum [13:0], off_sum [27:14], zero [31:28]
    input  logic [irps_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // kind [0]
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // channel [3:0], measure_request [4], level_mv [16:5],
    // obstacle_map [26:17], zero [31:27]
    output logic [irps_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // level_valid [0]
    output logic                            o_m_tuser,
    input  logic                            i_cfg_we,
    input  logic [irps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [irps_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SW = irps_pkg::SUM_W;

    irps_pkg::t_cfg    r_cfg;
    irps_pkg::t_result seq_result;
    irps_pkg::t_result r_result;

    logic                       r_in_valid;
    logic                       r_kind;
    logic [SW-1:0]              r_on_sum;
    logic [SW-1:0]              r_off_sum;
    logic                       r_out_valid;
    logic                       advance;
    logic                       fire;
    logic                       in_take;
    logic                       restart;
    logic [irps_pkg::LVL_W-1:0] level_mv;

    assign advance    = !r_out_valid || i_m_tready;
    assign fire       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;
    assign in_take    = i_s_tvalid && o_s_tready;
    assign restart    = i_cfg_we && (i_cfg_idx == irps_pkg::REG_SCAN_ENABLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scan_enable      <= 1'b0;
            r_cfg.interval_ticks   <= irps_pkg::INTERVAL_RST;
            r_cfg.threshold_ring   <= irps_pkg::THR_RING_RST;
            r_cfg.threshold_center <= irps_pkg::THR_CTR_RST;
            r_cfg.threshold_left   <= irps_pkg::THR_EDGE_RST;
            r_cfg.threshold_right  <= irps_pkg::THR_EDGE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                irps_pkg::REG_SCAN_ENABLE:      r_cfg.scan_enable      <= i_cfg_data[0];
                irps_pkg::REG_INTERVAL_TICKS:   r_cfg.interval_ticks   <= i_cfg_data[7:0];
                irps_pkg::REG_THRESHOLD_RING:   r_cfg.threshold_ring   <= i_cfg_data;
                irps_pkg::REG_THRESHOLD_CENTER: r_cfg.threshold_center <= i_cfg_data;
                irps_pkg::REG_THRESHOLD_LEFT:   r_cfg.threshold_left   <= i_cfg_data;
                irps_pkg::REG_THRESHOLD_RIGHT:  r_cfg.threshold_right  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind    <= i_s_tuser;
            r_on_sum  <= i_s_tdata[SW-1:0];
            r_off_sum <= i_s_tdata[2*SW-1:SW];
        end
    end

    irps_level #(
        .SAMPLES (SAMPLES)
    ) u_level (
        .i_on_sum   (r_on_sum),
        .i_off_sum  (r_off_sum),
        .o_level_mv (level_mv)
    );

    irps_seq #(
        .CHANNELS (CHANNELS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_restart  (restart),
        .i_fire     (fire),
        .i_kind     (r_kind),
        .i_level_mv (level_mv),
        .o_result   (seq_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= seq_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_result.obstacle_map, r_result.level_mv,
                         r_result.measure_request, r_result.channel};
    assign o_m_tuser  = r_result.level_valid;

endmodule

FILE: design/irps_checker.sv
// ----------------------------------------------------------------------------
// irps_checker
// Port-level checks of the ir proximity scan block, bound to the top level.
// ----------------------------------------------------------------------------
module irps_checker #(
    parameter int CHANNELS = irps_pkg::CHANNELS_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [irps_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input logic                            o_m_tuser
);

    // no result survives a reset
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("stalled result changed");

    // a fresh level puts the block into its waiting phase
    a_level_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> !o_m_tdata[4])
        else $error("measure request together with new level");

    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (32'(o_m_tdata[3:0]) < CHANNELS))
        else $error("channel out of range");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (32'(o_m_tdata[16:5]) <= irps_pkg::FULL_SCALE_MV))
        else $error("level above full scale");

endmodule

bind ir_proximity_scan_sequencer irps_checker #(
    .CHANNELS (CHANNELS)
) u_irps_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
